// File: rtl/csa_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the contiguous segment allocator.
// Used by csa_cell and contiguous_segment_allocator; depends on nothing.
package csa_pkg;

  localparam int SIZE_W       = 21;
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = 21'd1048576;
  localparam int MAX_SEG_DEF  = 32;
  localparam int OWNER_W_DEF  = 8;
  localparam int ADDR_W_DEF   = 20;

  // request kinds
  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_COMPACT = 2'd2;

  // fit policies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_NO_OWNER  = 3'd4;

  // cell operations
  localparam logic [2:0] MODE_HOLD    = 3'd0;
  localparam logic [2:0] MODE_WRITE   = 3'd1;
  localparam logic [2:0] MODE_INSERT  = 3'd2;
  localparam logic [2:0] MODE_MERGE   = 3'd3;
  localparam logic [2:0] MODE_REMOVE  = 3'd4;
  localparam logic [2:0] MODE_RELEASE = 3'd5;

  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] stop;
    logic              free;
  } seg_bounds_t;

  typedef struct packed {
    logic [2:0]  mode;
    seg_bounds_t bounds;
  } cell_ctl_t;

endpackage

// File: rtl/csa_cell.sv
`timescale 1ns / 1ps
// One table entry of the allocator: bounds, free mark and owner.
// Takes its neighbors' entries on shifts; uses csa_pkg types and codes.
module csa_cell #(
  parameter int IDX         = 0,
  parameter int OWNER_WIDTH = csa_pkg::OWNER_W_DEF,
  parameter int IDX_W       = 5,
  parameter int CNT_W       = 6
) (
  input  logic                    clk,
  input  csa_pkg::cell_ctl_t      ctl,
  input  logic [IDX_W-1:0]        pivot,
  input  logic [CNT_W-1:0]        count,
  input  logic [OWNER_WIDTH-1:0]  wr_owner,
  input  csa_pkg::seg_bounds_t    lower_bounds,
  input  logic [OWNER_WIDTH-1:0]  lower_owner,
  input  csa_pkg::seg_bounds_t    upper_bounds,
  input  logic [OWNER_WIDTH-1:0]  upper_owner,
  output csa_pkg::seg_bounds_t    bounds,
  output logic [OWNER_WIDTH-1:0]  seg_owner,
  output logic                    hit
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  csa_pkg::seg_bounds_t   bounds_next;
  logic [OWNER_WIDTH-1:0] seg_owner_next;
  logic [CNT_W-1:0]       piv;

  assign piv = CNT_W'(pivot);
  // owner match on a live, used entry
  assign hit = (MY_IDX < count) && !bounds.free && (seg_owner == wr_owner);

  // select the next entry
  always_comb begin
    bounds_next    = bounds;
    seg_owner_next = seg_owner;
    case (ctl.mode)
      csa_pkg::MODE_WRITE: begin
        if (MY_IDX == piv) begin
          bounds_next    = ctl.bounds;
          seg_owner_next = wr_owner;
        end
      end
      csa_pkg::MODE_INSERT: begin
        if (MY_IDX == piv) begin
          bounds_next    = ctl.bounds;
          seg_owner_next = wr_owner;
        end else if (MY_IDX > piv) begin
          bounds_next    = lower_bounds;
          seg_owner_next = lower_owner;
          if (MY_IDX == piv + CNT_W'(1)) bounds_next.start = ctl.bounds.stop;
        end
      end
      csa_pkg::MODE_MERGE: begin
        if (MY_IDX + CNT_W'(1) == piv) begin
          bounds_next.stop = upper_bounds.stop;
        end else if (MY_IDX >= piv) begin
          bounds_next    = upper_bounds;
          seg_owner_next = upper_owner;
        end
      end
      csa_pkg::MODE_REMOVE: begin
        if (MY_IDX >= piv) begin
          bounds_next    = upper_bounds;
          seg_owner_next = upper_owner;
        end
      end
      csa_pkg::MODE_RELEASE: begin
        if (hit) begin
          bounds_next.free = 1'b1;
          seg_owner_next   = '0;
        end
      end
      default: begin
        bounds_next    = bounds;
        seg_owner_next = seg_owner;
      end
    endcase
  end

  // hold the entry
  always_ff @(posedge clk) begin
    bounds    <= bounds_next;
    seg_owner <= seg_owner_next;
  end

endmodule

// File: rtl/contiguous_segment_allocator.sv
`timescale 1ns / 1ps
// Top level of the contiguous segment allocator: controller and row of cells.
// Depends on csa_pkg and csa_cell.
//
// Usage: a request (kind, owner, amount, fit_policy) enters on in_valid when
// in_stall is low; one result (status, start_address, segment_count) leaves on
// out_valid when out_stall is low. total_size is written on cfg_valid/cfg_ready
// while the block is idle and resets the table to one free segment.
// The table is a row of cells, one entry each; the controller walks it one
// entry per cycle through a single read port, except where a merge or removal
// holds the walk on its entry; inserts or removals shift the cells from the
// pivot up, each from its neighbor.
// One request is worked at a time: a new request is taken only after the last
// result has been loaded into the output register.
// Reset: the init state writes the full free segment; in_stall and cfg_ready
// hold off until it is done. A stalled result holds in the output register
// while the next request is accepted and worked; its result waits until the
// output register frees.
module contiguous_segment_allocator #(
  parameter int MAX_SEGMENTS = csa_pkg::MAX_SEG_DEF,
  parameter int OWNER_WIDTH  = csa_pkg::OWNER_W_DEF,
  parameter int ADDR_WIDTH   = csa_pkg::ADDR_W_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            kind,
  input  logic [OWNER_WIDTH-1:0]                owner,
  input  logic [csa_pkg::SIZE_W-1:0]            amount,
  input  logic [1:0]                            fit_policy,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            status,
  output logic [ADDR_WIDTH-1:0]                 start_address,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0]     segment_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [csa_pkg::SIZE_W-1:0]            cfg_data
);

  localparam int SW    = csa_pkg::SIZE_W;
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  localparam logic [2:0] S_INIT      = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_REQ_SCAN  = 3'd2;
  localparam logic [2:0] S_REQ_APPLY = 3'd3;
  localparam logic [2:0] S_REL_MARK  = 3'd4;
  localparam logic [2:0] S_REL_MERGE = 3'd5;
  localparam logic [2:0] S_CMP_SCAN  = 3'd6;
  localparam logic [2:0] S_FINISH    = 3'd7;

  // control registers
  logic [2:0]             state, state_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [CNT_W-1:0]       scan, scan_next;
  logic [SW-1:0]          total, total_next;
  logic                   found, found_next;
  logic                   prev_free, prev_free_next;
  logic                   cmp_tail, cmp_tail_next;
  // payload registers
  logic [1:0]             pol_q;
  logic [OWNER_WIDTH-1:0] who_q;
  logic [SW-1:0]          amt_q;
  logic [IDX_W-1:0]       pick, pick_next;
  logic [SW-1:0]          pick_len, pick_len_next;
  logic [SW-1:0]          pick_start, pick_start_next;
  logic [SW-1:0]          top, top_next;
  logic [2:0]             res_status, res_status_next;
  logic [SW-1:0]          res_addr, res_addr_next;

  // cell row
  csa_pkg::cell_ctl_t     ctl;
  logic [IDX_W-1:0]       pivot;
  logic [OWNER_WIDTH-1:0] wr_owner;
  csa_pkg::seg_bounds_t   cell_bounds [MAX_SEGMENTS];
  logic [OWNER_WIDTH-1:0] cell_owner  [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] cell_hit;

  csa_pkg::seg_bounds_t   sel;
  logic [OWNER_WIDTH-1:0] sel_owner;
  logic [SW-1:0]          len;
  logic                   cand, exact, better, last;
  logic                   take_in, take_cfg, out_load;
  logic [SW-1:0]          cfg_clamped;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      csa_pkg::seg_bounds_t   lo_b, up_b;
      logic [OWNER_WIDTH-1:0] lo_o, up_o;
      if (g == 0) begin : g_lo_edge
        assign lo_b = cell_bounds[g];
        assign lo_o = cell_owner[g];
      end else begin : g_lo
        assign lo_b = cell_bounds[g-1];
        assign lo_o = cell_owner[g-1];
      end
      if (g == MAX_SEGMENTS - 1) begin : g_up_edge
        assign up_b = cell_bounds[g];
        assign up_o = cell_owner[g];
      end else begin : g_up
        assign up_b = cell_bounds[g+1];
        assign up_o = cell_owner[g+1];
      end
      csa_cell #(
        .IDX(g), .OWNER_WIDTH(OWNER_WIDTH), .IDX_W(IDX_W), .CNT_W(CNT_W)
      ) u_cell (
        .clk(clk), .ctl(ctl), .pivot(pivot), .count(count), .wr_owner(wr_owner),
        .lower_bounds(lo_b), .lower_owner(lo_o),
        .upper_bounds(up_b), .upper_owner(up_o),
        .bounds(cell_bounds[g]), .seg_owner(cell_owner[g]), .hit(cell_hit[g])
      );
    end
  endgenerate

  // read port on the scanned entry
  assign sel       = cell_bounds[scan[IDX_W-1:0]];
  assign sel_owner = cell_owner[scan[IDX_W-1:0]];
  assign len       = sel.stop - sel.start;
  assign cand      = sel.free && (len >= amt_q);
  assign exact     = cand && (pol_q != csa_pkg::FIT_WORST) && (len == amt_q);
  assign better    = cand && (!found
                     || ((pol_q == csa_pkg::FIT_BEST) && (len < pick_len))
                     || ((pol_q == csa_pkg::FIT_WORST) && (len > pick_len)));
  assign last      = (scan + CNT_W'(1)) >= count;

  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign take_in   = in_valid && !in_stall;
  assign take_cfg  = cfg_valid && cfg_ready;
  assign out_load  = (state == S_FINISH) && (!out_valid || !out_stall);

  // clamp the written size to the legal range
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) cfg_clamped = SW'(1);
    if (cfg_data > csa_pkg::SIZE_LIMIT) cfg_clamped = csa_pkg::SIZE_LIMIT;
  end

  // sequence the table work
  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_next       = scan;
    total_next      = total;
    found_next      = found;
    prev_free_next  = prev_free;
    cmp_tail_next   = cmp_tail;
    pick_next       = pick;
    pick_len_next   = pick_len;
    pick_start_next = pick_start;
    top_next        = top;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    ctl.mode        = csa_pkg::MODE_HOLD;
    ctl.bounds      = '{start: '0, stop: total, free: 1'b1};
    pivot           = '0;
    wr_owner        = '0;
    case (state)
      S_INIT: begin
        ctl.mode   = csa_pkg::MODE_WRITE;
        count_next = CNT_W'(1);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (take_cfg) begin
          total_next        = cfg_clamped;
          ctl.mode          = csa_pkg::MODE_WRITE;
          ctl.bounds.stop   = cfg_clamped;
          count_next        = CNT_W'(1);
        end else if (take_in) begin
          res_addr_next   = '0;
          res_status_next = csa_pkg::ST_OK;
          scan_next       = '0;
          found_next      = 1'b0;
          prev_free_next  = 1'b0;
          cmp_tail_next   = 1'b0;
          top_next        = '0;
          state_next      = S_FINISH;
          case (kind)
            csa_pkg::KIND_REQUEST: begin
              if (amount > total) begin
                res_status_next = csa_pkg::ST_TOO_LARGE;
              end else if (count >= CNT_MAX) begin
                res_status_next = csa_pkg::ST_FULL;
              end else if (amount == '0 || fit_policy > csa_pkg::FIT_WORST) begin
                res_status_next = csa_pkg::ST_NO_FIT;
              end else begin
                state_next = S_REQ_SCAN;
              end
            end
            csa_pkg::KIND_RELEASE: state_next = S_REL_MARK;
            csa_pkg::KIND_COMPACT: state_next = S_CMP_SCAN;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_REQ_SCAN: begin
        scan_next = scan + CNT_W'(1);
        if (exact || better) begin
          pick_next       = scan[IDX_W-1:0];
          pick_len_next   = len;
          pick_start_next = sel.start;
          found_next      = 1'b1;
        end
        if (exact || (better && pol_q == csa_pkg::FIT_FIRST) || last) begin
          state_next = S_REQ_APPLY;
        end
      end
      S_REQ_APPLY: begin
        state_next = S_FINISH;
        if (!found) begin
          res_status_next = csa_pkg::ST_NO_FIT;
        end else begin
          res_addr_next = pick_start;
          pivot         = pick;
          wr_owner      = who_q;
          ctl.bounds    = '{start: pick_start, stop: pick_start + amt_q, free: 1'b0};
          if (pick_len == amt_q) begin
            ctl.mode = csa_pkg::MODE_WRITE;
          end else begin
            ctl.mode   = csa_pkg::MODE_INSERT;
            count_next = count + CNT_W'(1);
          end
        end
      end
      S_REL_MARK: begin
        wr_owner = who_q;
        ctl.mode = csa_pkg::MODE_RELEASE;
        if (|cell_hit) begin
          state_next = S_REL_MERGE;
        end else begin
          res_status_next = csa_pkg::ST_NO_OWNER;
          state_next      = S_FINISH;
        end
      end
      S_REL_MERGE: begin
        if (scan >= count) begin
          state_next = S_FINISH;
        end else if (prev_free && sel.free) begin
          ctl.mode   = csa_pkg::MODE_MERGE;
          pivot      = scan[IDX_W-1:0];
          count_next = count - CNT_W'(1);
        end else begin
          prev_free_next = sel.free;
          scan_next      = scan + CNT_W'(1);
        end
      end
      S_CMP_SCAN: begin
        if (cmp_tail) begin
          state_next = S_FINISH;
          if (top < total && count < CNT_MAX) begin
            ctl.mode   = csa_pkg::MODE_WRITE;
            pivot      = count[IDX_W-1:0];
            ctl.bounds = '{start: top, stop: total, free: 1'b1};
            count_next = count + CNT_W'(1);
          end
        end else if (scan >= count) begin
          cmp_tail_next = 1'b1;
        end else if (sel.free) begin
          ctl.mode   = csa_pkg::MODE_REMOVE;
          pivot      = scan[IDX_W-1:0];
          count_next = count - CNT_W'(1);
        end else begin
          ctl.mode   = csa_pkg::MODE_WRITE;
          pivot      = scan[IDX_W-1:0];
          wr_owner   = sel_owner;
          ctl.bounds = '{start: top, stop: top + len, free: 1'b0};
          top_next   = top + len;
          scan_next  = scan + CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CNT_W'(1);
      scan      <= '0;
      total     <= csa_pkg::SIZE_LIMIT;
      found     <= 1'b0;
      prev_free <= 1'b0;
      cmp_tail  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      scan      <= scan_next;
      total     <= total_next;
      found     <= found_next;
      prev_free <= prev_free_next;
      cmp_tail  <= cmp_tail_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // hold request fields and working values
  always_ff @(posedge clk) begin
    if (take_in) begin
      pol_q <= fit_policy;
      who_q <= owner;
      amt_q <= amount;
    end
    pick       <= pick_next;
    pick_len   <= pick_len_next;
    pick_start <= pick_start_next;
    top        <= top_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    if (out_load) begin
      status        <= res_status;
      segment_count <= count;
      start_address <= ADDR_WIDTH'(res_addr);
    end
  end

  // table never exceeds its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("entry count above capacity");

  // idle table always holds at least one entry
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> count != '0)
    else $error("empty table while idle");

  // first entry always starts at unit zero once idle
  a_first_start: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cell_bounds[0].start == '0)
    else $error("first segment does not start at zero");

  // a successful allocation lies inside the managed memory
  a_alloc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_REQ_APPLY && found) |-> (pick_start + amt_q) <= total)
    else $error("allocation beyond memory");

endmodule
